// ----- rtl/core/stb_pkg.sv -----
package stb_pkg;

    // Bank size and derived widths
    localparam int TIMERS   = 8;
    localparam int IDX_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int CNT_W    = $clog2(TIMERS + 1);
    localparam int ID_W     = 4;
    localparam int PERIOD_W = 32;
    localparam int RUN_W    = 31;
    localparam int DELAY_W  = 16;
    localparam int MASK_W   = 8;

    localparam logic [RUN_W-1:0] RUN_LIMIT = 31'h7fffffff;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_CHECK   = 3'd3,
        OP_ELAPSED = 3'd4,
        OP_DELAY   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_USED   = 2'd1,
        ST_UNUSED = 2'd2,
        ST_BADID  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EXEC
    } t_state;

    // Sequencer to timer store
    typedef struct packed {
        logic                rd_en;
        logic [IDX_W-1:0]    rd_idx;
        logic                upd_en;
        logic [IDX_W-1:0]    upd_idx;
        logic                create;
        logic                delete;
        logic [IDX_W-1:0]    id;
        logic [PERIOD_W-1:0] period;
        logic                mode;
    } t_tmr_ctrl;

    // Timer store back to sequencer
    typedef struct packed {
        logic in_use;
        logic expired;
        logic hit;
    } t_tmr_stat;

endpackage

// ----- rtl/core/stb_timers.sv -----
module stb_timers (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stb_pkg::t_tmr_ctrl i_ctrl,
    output stb_pkg::t_tmr_stat o_stat
);

    // Count and reload storage; contents only meaningful while in use
    logic [stb_pkg::PERIOD_W-1:0] rem_mem [stb_pkg::TIMERS];
    logic [stb_pkg::PERIOD_W-1:0] rel_mem [stb_pkg::TIMERS];

    logic [stb_pkg::PERIOD_W-1:0] r_rem_q;
    logic [stb_pkg::PERIOD_W-1:0] r_rel_q;

    logic [stb_pkg::TIMERS-1:0] r_in_use;
    logic [stb_pkg::TIMERS-1:0] r_mode;
    logic [stb_pkg::TIMERS-1:0] r_flag;

    logic                         live;
    logic                         reach_zero;
    logic [stb_pkg::PERIOD_W-1:0] dec;
    logic [stb_pkg::PERIOD_W-1:0] n_rem;
    logic                         upd_mode;

    // Registered read port, one entry per sweep cycle
    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rem_q <= rem_mem[i_ctrl.rd_idx];
            r_rel_q <= rel_mem[i_ctrl.rd_idx];
        end
    end

    // Shared decrement / zero-compare unit
    always_comb begin
        upd_mode   = r_mode[i_ctrl.upd_idx];
        live       = r_in_use[i_ctrl.upd_idx] && (r_rem_q != '0);
        dec        = r_rem_q - stb_pkg::PERIOD_W'(1);
        reach_zero = (dec == '0);
        n_rem      = (reach_zero && upd_mode) ? r_rel_q : dec;
    end

    // Write port: create loads, sweep writes back
    always_ff @(posedge i_clk) begin
        if (i_ctrl.create) begin
            rem_mem[i_ctrl.id] <= i_ctrl.period;
            rel_mem[i_ctrl.id] <= i_ctrl.period;
        end else if (i_ctrl.upd_en && live) begin
            rem_mem[i_ctrl.upd_idx] <= n_rem;
        end
    end

    // Per-timer flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_mode   <= '0;
            r_flag   <= '0;
        end else begin
            if (i_ctrl.create) begin
                r_in_use[i_ctrl.id] <= 1'b1;
                r_mode[i_ctrl.id]   <= i_ctrl.mode;
                r_flag[i_ctrl.id]   <= 1'b0;
            end else if (i_ctrl.delete) begin
                r_in_use[i_ctrl.id] <= 1'b0;
                r_mode[i_ctrl.id]   <= 1'b0;
            end else if (i_ctrl.upd_en && live && reach_zero) begin
                r_flag[i_ctrl.upd_idx] <= !upd_mode;
            end
        end
    end

    assign o_stat.in_use  = r_in_use[i_ctrl.id];
    assign o_stat.expired = r_flag[i_ctrl.id];
    assign o_stat.hit     = i_ctrl.upd_en && live && reach_zero;

endmodule

// ----- rtl/core/soft_timer_bank.sv -----
// Bank of software timers with a run-time tick counter and a delay counter.
// Command channel: an item is taken at a rising edge with start high and
// busy low; its fields are sampled from the i_ ports at that edge.
// Result channel: o_strobe is high for exactly one cycle per item, with all
// o_ result ports valid in that cycle. The receiver cannot hold results off.
// Latency, accept edge to strobe cycle:
//   tick:        TIMERS + 3 cycles (11 with 8 timers)
//   other ops:   2 cycles
// busy drops in the strobe cycle, so a new item may be taken at the edge
// that ends it: one tick every TIMERS + 3 cycles, other ops every 2.
// The tick time is set by the sweep over the timer store, one entry per
// cycle through a single read port and one shared decrement/compare unit.
// o_run_time and o_delay_done show the state after the item.
// Reset (i_rst_n low, synchronous) frees all timers, clears the run time,
// the pending delay and its done flag, and returns the sequencer to idle.
module soft_timer_bank (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_operation,
    input  logic [stb_pkg::ID_W-1:0]     i_timer_id,
    input  logic [stb_pkg::PERIOD_W-1:0] i_period,
    input  logic                         i_auto_reload,
    input  logic [stb_pkg::RUN_W-1:0]    i_last_time,
    input  logic [stb_pkg::DELAY_W-1:0]  i_delay_ms,
    output logic                         o_strobe,
    output logic [1:0]                   o_status,
    output logic                         o_timer_expired,
    output logic [stb_pkg::MASK_W-1:0]   o_expired_mask,
    output logic [stb_pkg::RUN_W-1:0]    o_run_time,
    output logic [stb_pkg::RUN_W-1:0]    o_elapsed,
    output logic                         o_delay_done
);

    stb_pkg::t_state r_state, n_state;

    // Latched command beat
    stb_pkg::t_op                 r_op;
    logic [stb_pkg::ID_W-1:0]     r_id;
    logic [stb_pkg::PERIOD_W-1:0] r_period;
    logic                         r_mode;
    logic [stb_pkg::RUN_W-1:0]    r_last;
    logic [stb_pkg::DELAY_W-1:0]  r_dly;

    logic [stb_pkg::CNT_W-1:0]    r_idx;
    logic [stb_pkg::RUN_W-1:0]    r_tick_count, n_tick_count;
    logic [stb_pkg::DELAY_W-1:0]  r_delay_left, n_delay_left;
    logic                         r_delay_flag, n_delay_flag;

    stb_pkg::t_status             r_status, n_status;
    logic                         r_expired, n_expired;
    logic [stb_pkg::MASK_W-1:0]   r_mask;
    logic [stb_pkg::RUN_W-1:0]    r_elapsed, n_elapsed;
    logic                         r_strobe;

    logic                         accept;
    logic                         id_ok;
    logic                         sweep_last;
    logic [stb_pkg::ID_W-1:0]     upd_id;
    logic [stb_pkg::RUN_W:0]      el_diff;
    logic [stb_pkg::RUN_W-1:0]    tc_inc;

    stb_pkg::t_tmr_ctrl           ctrl;
    stb_pkg::t_tmr_stat           stat;

    assign accept     = start && !busy;
    assign id_ok      = {1'b0, r_id} < (stb_pkg::ID_W + 1)'(stb_pkg::TIMERS);
    assign sweep_last = (r_idx == stb_pkg::CNT_W'(stb_pkg::TIMERS));
    assign upd_id     = stb_pkg::ID_W'(ctrl.upd_idx);

    stb_timers u_timers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .o_stat  (stat)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stb_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (stb_pkg::t_op'(i_operation) == stb_pkg::OP_TICK)
                              ? stb_pkg::S_SWEEP : stb_pkg::S_EXEC;
                end
            end
            stb_pkg::S_SWEEP: begin
                if (sweep_last) begin
                    n_state = stb_pkg::S_EXEC;
                end
            end
            stb_pkg::S_EXEC: n_state = stb_pkg::S_IDLE;
            default:         n_state = stb_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: sweep reads entry idx while writing back idx-1
    always_comb begin
        busy         = (r_state != stb_pkg::S_IDLE);
        ctrl.rd_en   = 1'b0;
        ctrl.rd_idx  = r_idx[stb_pkg::IDX_W-1:0];
        ctrl.upd_en  = 1'b0;
        ctrl.upd_idx = stb_pkg::IDX_W'(r_idx - stb_pkg::CNT_W'(1));
        ctrl.create  = 1'b0;
        ctrl.delete  = 1'b0;
        ctrl.id      = r_id[stb_pkg::IDX_W-1:0];
        ctrl.period  = r_period;
        ctrl.mode    = r_mode;
        unique case (r_state)
            stb_pkg::S_SWEEP: begin
                ctrl.rd_en  = !sweep_last;
                ctrl.upd_en = (r_idx != '0);
            end
            stb_pkg::S_EXEC: begin
                ctrl.create = (r_op == stb_pkg::OP_CREATE) && id_ok && !stat.in_use;
                ctrl.delete = (r_op == stb_pkg::OP_DELETE) && id_ok && stat.in_use;
            end
            default: ;
        endcase
    end

    // Elapsed with wrap: below last_time the span loses one count
    assign el_diff = {1'b0, r_tick_count} - {1'b0, r_last};
    assign tc_inc  = r_tick_count + stb_pkg::RUN_W'(1);

    // Scalar result of the item
    always_comb begin
        n_status     = stb_pkg::ST_OK;
        n_expired    = 1'b0;
        n_elapsed    = '0;
        n_tick_count = r_tick_count;
        n_delay_left = r_delay_left;
        n_delay_flag = r_delay_flag;
        case (r_op)
            stb_pkg::OP_TICK: begin
                if (r_delay_left != '0) begin
                    n_delay_left = r_delay_left - stb_pkg::DELAY_W'(1);
                    if (r_delay_left == stb_pkg::DELAY_W'(1)) begin
                        n_delay_flag = 1'b1;
                    end
                end
                n_tick_count = (tc_inc == stb_pkg::RUN_LIMIT) ? '0 : tc_inc;
            end
            stb_pkg::OP_CREATE: begin
                priority if (!id_ok)     n_status = stb_pkg::ST_BADID;
                else if (stat.in_use)    n_status = stb_pkg::ST_USED;
                else                     n_status = stb_pkg::ST_OK;
            end
            stb_pkg::OP_DELETE: begin
                priority if (!id_ok)     n_status = stb_pkg::ST_BADID;
                else if (!stat.in_use)   n_status = stb_pkg::ST_UNUSED;
                else                     n_status = stb_pkg::ST_OK;
            end
            stb_pkg::OP_CHECK: begin
                priority if (!id_ok)     n_status = stb_pkg::ST_BADID;
                else if (!stat.in_use)   n_status = stb_pkg::ST_UNUSED;
                else                     n_expired = stat.expired;
            end
            stb_pkg::OP_ELAPSED: begin
                n_elapsed = el_diff[stb_pkg::RUN_W-1:0]
                            - stb_pkg::RUN_W'(el_diff[stb_pkg::RUN_W]);
            end
            stb_pkg::OP_DELAY: begin
                if (r_dly != '0) begin
                    n_delay_left = (r_dly == stb_pkg::DELAY_W'(1))
                                   ? stb_pkg::DELAY_W'(2) : r_dly;
                    n_delay_flag = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stb_pkg::S_IDLE;
            r_idx        <= '0;
            r_tick_count <= '0;
            r_delay_left <= '0;
            r_delay_flag <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == stb_pkg::S_EXEC);
            if (accept) begin
                r_idx <= '0;
            end else if (r_state == stb_pkg::S_SWEEP) begin
                r_idx <= r_idx + stb_pkg::CNT_W'(1);
            end
            if (r_state == stb_pkg::S_EXEC) begin
                r_tick_count <= n_tick_count;
                r_delay_left <= n_delay_left;
                r_delay_flag <= n_delay_flag;
            end
        end
    end

    // Command beat capture and result registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= stb_pkg::t_op'(i_operation);
            r_id     <= i_timer_id;
            r_period <= i_period;
            r_mode   <= i_auto_reload;
            r_last   <= i_last_time;
            r_dly    <= i_delay_ms;
            r_mask   <= '0;
        end else if (stat.hit && !upd_id[3]) begin
            r_mask[upd_id[2:0]] <= 1'b1;
        end
        if (r_state == stb_pkg::S_EXEC) begin
            r_status  <= n_status;
            r_expired <= n_expired;
            r_elapsed <= n_elapsed;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_timer_expired = r_expired;
    assign o_expired_mask  = r_mask;
    assign o_run_time      = r_tick_count;
    assign o_elapsed       = r_elapsed;
    assign o_delay_done    = r_delay_flag;

    // Checks
    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stb_pkg::S_EXEC) |=> o_strobe)
        else $error("result strobe missing after execute");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted beat did not raise busy");

    a_sweep_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stb_pkg::S_SWEEP) |-> (r_idx <= stb_pkg::CNT_W'(stb_pkg::TIMERS)))
        else $error("sweep index out of range");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != stb_pkg::ST_OK))
        |-> ((o_expired_mask == '0) && !o_timer_expired))
        else $error("failed command reported expiry");

endmodule
